// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BOL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bol check failed");

// next-cycle implication, disabled during reset
`define BOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bol check failed");

`endif

// File: rtl/core/bol_pkg.sv
// shared types and constants of the bounded ordered list
// no dependencies
package bol_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int DATA_W     = 32;
   localparam int OPC_W      = 4;
   localparam int POS_W      = 5;
   localparam int CNT_W      = 5;
   localparam int STAT_W     = 2;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_BACK   = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_INSERT     = 4'd4,
      OP_ERASE      = 4'd5,
      OP_READ_AT    = 4'd6,
      OP_FRONT      = 4'd7,
      OP_BACK       = 4'd8
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EDIT_NONE,
      EDIT_INSERT,
      EDIT_REMOVE
   } edit_type;

   typedef enum logic [1:0] {
      ADDR_POS,
      ADDR_HEAD,
      ADDR_TAIL,
      ADDR_END
   } addr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_step_type;

   // controller to datapath
   typedef struct packed {
      logic         apply;
      edit_type     edit;
      addr_sel_type addr_sel;
      cnt_step_type cnt_step;
      logic         rd_en;
      status_type   status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_above_count;
      logic pos_not_below_count;
   } flags_type;

endpackage

// File: rtl/core/bol_datapath.sv
// shift-register cells, element count and result registers
// depends on bol_pkg
module bol_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  bol_pkg::cmd_type                cmd,
   input  logic [bol_pkg::POS_W-1:0]       req_position,
   input  logic signed [bol_pkg::DATA_W-1:0] req_value,
   output bol_pkg::flags_type              flags,
   output logic signed [bol_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bol_pkg::CNT_W-1:0]       rsp_count,
   output logic [bol_pkg::STAT_W-1:0]      rsp_status
);
   import bol_pkg::*;

   logic [DATA_W-1:0] cell_ff [LIST_DEPTH];
   logic [DATA_W-1:0] cell_in [LIST_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] rd_value_ff;
   logic [DATA_W-1:0] rd_value_in;
   status_type        status_ff;
   logic [CNT_W-1:0]  count_less1;
   logic [IDX_W-1:0]  addr;

   // status towards the controller
   assign flags.full                = (count_ff == CNT_W'(LIST_DEPTH));
   assign flags.empty               = (count_ff == '0);
   assign flags.pos_above_count     = (req_position > count_ff);
   assign flags.pos_not_below_count = (req_position >= count_ff);

   // working address for edits and reads
   assign count_less1 = count_ff - CNT_W'(1);

   always_comb begin
      case (cmd.addr_sel)
         ADDR_POS:  addr = req_position[IDX_W-1:0];
         ADDR_HEAD: addr = '0;
         ADDR_TAIL: addr = count_less1[IDX_W-1:0];
         default:   addr = count_ff[IDX_W-1:0];
      endcase
   end

   // per-cell next value: take the lower or upper neighbour, the new value, or hold
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      always_comb begin
         cell_in[i] = cell_ff[i];
         case (cmd.edit)
            EDIT_INSERT: begin
               if (IDX_W'(i) == addr) begin
                  cell_in[i] = req_value;
               end
               if (i > 0) begin
                  if (IDX_W'(i) > addr) begin
                     cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
                  end
               end
            end
            EDIT_REMOVE: begin
               if (i < LIST_DEPTH - 1) begin
                  if (IDX_W'(i) >= addr) begin
                     cell_in[i] = cell_ff[(i < LIST_DEPTH - 1) ? i + 1 : i];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // count update
   always_comb begin
      case (cmd.cnt_step)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_less1;
         default: count_in = count_ff;
      endcase
   end

   // read port
   assign rd_value_in = cmd.rd_en ? cell_ff[addr] : '0;

   // cells and result payload
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         for (int i = 0; i < LIST_DEPTH; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         rd_value_ff <= rd_value_in;
         status_ff   <= cmd.status;
      end
   end

   // element count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   assign rsp_read_value = rd_value_ff;
   assign rsp_count      = count_ff;
   assign rsp_status     = status_ff;

endmodule

// File: rtl/core/bol_controller.sv
// handshake state machine and operation decoder
// depends on bol_pkg
module bol_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bol_pkg::OPC_W-1:0]   req_opcode,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  bol_pkg::flags_type          flags,
   output bol_pkg::cmd_type            cmd
);
   import bol_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // a new transfer is taken unless a held result is stalled
   assign req_stall = (state_ff == S_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_HOLD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (accept)          state_in = S_HOLD;
            else if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // operation decode
   always_comb begin
      cmd.apply    = accept;
      cmd.edit     = EDIT_NONE;
      cmd.addr_sel = ADDR_POS;
      cmd.cnt_step = CNT_HOLD;
      cmd.rd_en    = 1'b0;
      cmd.status   = ST_OK;
      unique case (opcode_type'(req_opcode))
         OP_PUSH_BACK: begin
            if (flags.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.edit     = EDIT_INSERT;
               cmd.addr_sel = ADDR_END;
               cmd.cnt_step = CNT_INC;
            end
         end
         OP_PUSH_FRONT: begin
            if (flags.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.edit     = EDIT_INSERT;
               cmd.addr_sel = ADDR_HEAD;
               cmd.cnt_step = CNT_INC;
            end
         end
         OP_POP_BACK: begin
            if (flags.empty) cmd.status   = ST_EMPTY;
            else             cmd.cnt_step = CNT_DEC;
         end
         OP_POP_FRONT: begin
            if (flags.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.edit     = EDIT_REMOVE;
               cmd.addr_sel = ADDR_HEAD;
               cmd.cnt_step = CNT_DEC;
            end
         end
         OP_INSERT: begin
            if (flags.pos_above_count) begin
               cmd.status = ST_BADPOS;
            end else if (flags.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.edit     = EDIT_INSERT;
               cmd.cnt_step = CNT_INC;
            end
         end
         OP_ERASE: begin
            if (flags.empty) begin
               cmd.status = ST_EMPTY;
            end else if (flags.pos_not_below_count) begin
               cmd.status = ST_BADPOS;
            end else begin
               cmd.edit     = EDIT_REMOVE;
               cmd.cnt_step = CNT_DEC;
            end
         end
         OP_READ_AT: begin
            if (flags.empty)                    cmd.status = ST_EMPTY;
            else if (flags.pos_not_below_count) cmd.status = ST_BADPOS;
            else                                cmd.rd_en  = 1'b1;
         end
         OP_FRONT: begin
            if (flags.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.addr_sel = ADDR_HEAD;
               cmd.rd_en    = 1'b1;
            end
         end
         OP_BACK: begin
            if (flags.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.addr_sel = ADDR_TAIL;
               cmd.rd_en    = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/core/bounded_ordered_list_unit.sv
// channel   | handshake            | payload
// req       | req_valid/req_stall  | req_opcode, req_position, req_value
// rsp       | rsp_valid/rsp_stall  | rsp_read_value, rsp_count, rsp_status
//
// every operation finishes in the cycle it is taken: all cells shift in parallel
// the result appears in the cycle after the transfer in, held in an output register
// a new transfer is taken while a result waits unless rsp_stall is high
// sustained rate is one operation per cycle while rsp_stall stays low; reset empties the list at once
// depends on bol_pkg, bol_controller and bol_datapath
module bounded_ordered_list_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bol_pkg::OPC_W-1:0]         req_opcode,
   input  logic [bol_pkg::POS_W-1:0]         req_position,
   input  logic signed [bol_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bol_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bol_pkg::CNT_W-1:0]         rsp_count,
   output logic [bol_pkg::STAT_W-1:0]        rsp_status
);
   import bol_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   // control
   bol_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .flags      (flags),
      .cmd        (cmd)
   );

   // storage and results
   bol_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .flags          (flags),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

endmodule

// File: rtl/core/bol_checker.sv
// port-level checks for the bounded ordered list, bound to the top level
// depends on bol_pkg and assert_macros.svh
`include "assert_macros.svh"

module bol_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [bol_pkg::OPC_W-1:0]         req_opcode,
   input logic [bol_pkg::POS_W-1:0]         req_position,
   input logic signed [bol_pkg::DATA_W-1:0] req_value,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [bol_pkg::DATA_W-1:0] rsp_read_value,
   input logic [bol_pkg::CNT_W-1:0]         rsp_count,
   input logic [bol_pkg::STAT_W-1:0]        rsp_status
);
   import bol_pkg::*;

   // a transfer in gives a result on the next cycle
   `BOL_ASSERT_NEXT(a_result_follows, clock, reset, req_valid && !req_stall, rsp_valid)

   // count never passes the capacity
   `BOL_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_count <= CNT_W'(LIST_DEPTH))

   // a full refusal only on a full list
   `BOL_ASSERT_SAME(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL,
                    rsp_count == CNT_W'(LIST_DEPTH))

   // an empty refusal only on an empty list, and reads nothing
   `BOL_ASSERT_SAME(a_empty_count, clock, reset, rsp_valid && rsp_status == ST_EMPTY,
                    rsp_count == '0 && rsp_read_value == '0)

   // a stalled result holds
   `BOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_read_value) && $stable(rsp_count))

endmodule

bind bounded_ordered_list_unit bol_checker u_checker (.*);

// File: bench/bounded_ordered_list_unit_tb.sv
// self-checking bench for bounded_ordered_list_unit: directed edge cases then random traffic
// keeps a shadow list to predict each response; depends on bol_pkg and the unit itself
module bounded_ordered_list_unit_tb;
   import bol_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]         count;
      status_type               status;
   } list_outcome_type;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic [OPC_W-1:0]         req_opcode   = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]         rsp_count;
   logic [STAT_W-1:0]        rsp_status;

   // shadow copy of the list
   logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
   int                       shadow_count = 0;

   list_outcome_type pending_results [$];
   int               error_count  = 0;
   int               quiet_cycles = 0;
   bit               no_idle      = 1'b0;

   bounded_ordered_list_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one operation to the shadow list and return the response it should give
   function automatic list_outcome_type apply_list_op(input logic [OPC_W-1:0] opc,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [DATA_W-1:0] val);
      list_outcome_type res;
      bit               full;
      bit               empty;
      int               p;
      int               i;
      res.read_value = '0;
      res.status     = ST_OK;
      full  = (shadow_count >= LIST_DEPTH);
      empty = (shadow_count == 0);
      p     = int'(pos);
      case (opc)
         OP_PUSH_BACK: begin
            if (full) res.status = ST_FULL;
            else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) res.status = ST_FULL;
            else begin
               for (i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[0] = val;
               shadow_count++;
            end
         end
         OP_POP_BACK: begin
            if (empty) res.status = ST_EMPTY;
            else shadow_count--;
         end
         OP_POP_FRONT: begin
            if (empty) res.status = ST_EMPTY;
            else begin
               for (i = 0; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
            end
         end
         OP_INSERT: begin
            // a bad position wins over a full list
            if (p > shadow_count) res.status = ST_BADPOS;
            else if (full) res.status = ST_FULL;
            else begin
               for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = val;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (empty) res.status = ST_EMPTY;
            else if (p >= shadow_count) res.status = ST_BADPOS;
            else begin
               for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
            end
         end
         OP_READ_AT: begin
            if (empty) res.status = ST_EMPTY;
            else if (p >= shadow_count) res.status = ST_BADPOS;
            else res.read_value = shadow_entries[p];
         end
         OP_FRONT: begin
            if (empty) res.status = ST_EMPTY;
            else res.read_value = shadow_entries[0];
         end
         OP_BACK: begin
            if (empty) res.status = ST_EMPTY;
            else res.read_value = shadow_entries[shadow_count-1];
         end
         default: begin
            // unknown opcodes leave the list alone
         end
      endcase
      res.count = CNT_W'(shadow_count);
      return res;
   endfunction

   // value mix with the extremes well represented
   function automatic logic signed [DATA_W-1:0] random_element();
      case ($urandom_range(9))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // drive one request and wait for its transfer, then record the expected response
   task automatic send_list_op(input logic [OPC_W-1:0] opc, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= opc;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), apply_list_op(opc, pos, val));
      @(negedge clock);
   endtask

   // grow_pct sets how often the list is made longer rather than shorter or read
   task automatic send_random_op(input int grow_pct);
      logic [OPC_W-1:0] opc;
      logic [POS_W-1:0] pos;
      if ($urandom_range(99) < 4) opc = OPC_W'($urandom_range(15, OP_BACK + 1));
      else if ($urandom_range(99) < grow_pct) begin
         case ($urandom_range(2))
            0:       opc = OP_PUSH_BACK;
            1:       opc = OP_PUSH_FRONT;
            default: opc = OP_INSERT;
         endcase
      end else begin
         case ($urandom_range(5))
            0:       opc = OP_POP_BACK;
            1:       opc = OP_POP_FRONT;
            2:       opc = OP_ERASE;
            3:       opc = OP_READ_AT;
            4:       opc = OP_FRONT;
            default: opc = OP_BACK;
         endcase
      end
      // positions mostly in range, sometimes anything the field holds
      if ($urandom_range(99) < 15) pos = POS_W'($urandom);
      else if (opc == OP_INSERT) pos = POS_W'($urandom_range(shadow_count));
      else if (shadow_count > 0) pos = POS_W'($urandom_range(shadow_count - 1));
      else pos = '0;
      send_list_op(opc, pos, random_element());
   endtask

   // every removing or reading operation on an empty list, plus an out-of-range insert and an unknown opcode
   task automatic test_empty_refusals();
      send_list_op(OP_POP_BACK, '0, '0);
      send_list_op(OP_POP_FRONT, '0, '0);
      send_list_op(OP_ERASE, 5'd5, '0);
      send_list_op(OP_READ_AT, '0, '0);
      send_list_op(OP_FRONT, '0, '0);
      send_list_op(OP_BACK, '0, '0);
      send_list_op(OP_INSERT, 5'd1, 32'sd7);
      send_list_op(OPC_W'(15), '1, '1);
   endtask

   // fill to capacity through every adding path, then knock on the full list
   task automatic test_full_list();
      send_list_op(OP_PUSH_BACK, '0, {1'b1, {(DATA_W-1){1'b0}}});
      send_list_op(OP_PUSH_FRONT, '0, {1'b0, {(DATA_W-1){1'b1}}});
      send_list_op(OP_INSERT, 5'd1, -32'sd1);
      send_list_op(OP_INSERT, 5'd3, 32'sh5555_5555);
      send_list_op(OP_INSERT, 5'd0, '0);
      while (shadow_count < LIST_DEPTH) send_list_op(OP_PUSH_BACK, '0, random_element());
      send_list_op(OP_PUSH_BACK, '0, 32'sd1);
      send_list_op(OP_PUSH_FRONT, '0, 32'sd2);
      send_list_op(OP_INSERT, 5'd16, 32'sd3);
      send_list_op(OP_INSERT, 5'd17, 32'sd4);
      send_list_op(OP_READ_AT, 5'd16, '0);
      send_list_op(OP_BACK, '0, '0);
   endtask

   task automatic test_random_mix(input int n_items);
      int k;
      for (k = 0; k < n_items; k++) send_random_op(50);
   endtask

   // swing between full and empty so both boundaries are hit often
   task automatic test_fill_drain(input int n_items);
      int k;
      bit growing;
      growing = 1'b1;
      for (k = 0; k < n_items; k++) begin
         send_random_op(growing ? 85 : 15);
         if (shadow_count == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         else if (shadow_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
      end
   endtask

   // long stretch with neither side idling
   task automatic test_back_to_back(input int n_items);
      int k;
      no_idle = 1'b1;
      for (k = 0; k < n_items; k++) send_random_op(50);
      no_idle = 1'b0;
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 25);
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      list_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with nothing expected");
            error_count++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_refusals();
      test_full_list();
      test_random_mix(220);
      test_fill_drain(240);
      test_back_to_back(140);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
